// ===== rtl/s3f_pkg.sv =====
// ----------------------------------------------------------------------------
// s3f_pkg
// Shared types and constants for the selectable 3x3 image filter.
// ----------------------------------------------------------------------------
`default_nettype none

package s3f_pkg;

  localparam int MAX_ROW_PIXELS_DEF = 1024;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int Q_DEPTH    = 4;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd3;

  // filter modes; anything not listed passes the pixel
  localparam logic [2:0] MODE_SOBEL     = 3'd2;
  localparam logic [2:0] MODE_THRESHOLD = 3'd3;
  localparam logic [2:0] MODE_GAUSSIAN  = 3'd4;
  localparam logic [2:0] MODE_NEGATIVE  = 3'd5;
  localparam logic [2:0] MODE_SHARPEN   = 3'd6;

  localparam logic [2:0]  FILTER_MODE_RST  = 3'd0;
  localparam logic [7:0]  THRESHOLD_RST    = 8'd0;
  localparam logic [10:0] ROW_WIDTH_RST    = 11'd640;
  localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;

  localparam logic [7:0] PIX_MAX = 8'd255;

  typedef struct packed {
    logic [2:0]  filter_mode;
    logic [7:0]  threshold_level;
    logic [10:0] row_width;
    logic [15:0] frame_height;
  } cfg_t;

  // one classified pixel on its way from front to back
  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] line0;   // two rows up
    logic [PIX_W-1:0] line1;   // one row up
    logic             win_ok;  // full 3x3 neighbourhood available
    logic             row_last;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/s3f_in_if.sv =====
// ----------------------------------------------------------------------------
// s3f_in_if
// Pixel input channel: valid/ready with one grayscale pixel per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface s3f_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/s3f_out_if.sv =====
// ----------------------------------------------------------------------------
// s3f_out_if
// Result channel: valid/ready with filtered pixel and row-last mark per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface s3f_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       row_last;

  modport source (output valid, output pixel_out, output row_last, input ready);
  modport sink   (input valid, input pixel_out, input row_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/s3f_front.sv =====
// ----------------------------------------------------------------------------
// s3f_front
// Raster counters, two-row line store and item classification.
// ----------------------------------------------------------------------------
`default_nettype none

module s3f_front
  import s3f_pkg::*;
#(
  parameter int MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  s3f_in_if.sink     in_ch,
  output item_t      q_item,
  output logic       q_push,
  input  wire logic  q_ready
);

  localparam int CW = $clog2(MAX_ROW_PIXELS);

  logic [CW-1:0] col_r, col_nxt;
  logic [15:0]   row_r, row_nxt;
  logic [CW-1:0] last_col;
  logic [15:0]   last_row;
  logic          is_last, win_ok;
  logic          accept;

  // stage 1: pixel waiting for its line store read
  logic          s1_full_r;
  logic [7:0]    s1_px_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_win_ok_r;
  logic          s1_last_r;
  logic [15:0]   s1_lines;

  // line store: [15:8] two rows up, [7:0] one row up
  logic [15:0]   lstore [MAX_ROW_PIXELS];
  logic [15:0]   mem_q_r;
  logic [15:0]   byp_r;
  logic          byp_sel_r;

  always_comb begin
    if (cfg.row_width == '0) begin
      last_col = '0;
    end else if (32'(cfg.row_width) > 32'(MAX_ROW_PIXELS)) begin
      last_col = CW'(MAX_ROW_PIXELS - 1);
    end else begin
      last_col = CW'(cfg.row_width - 11'd1);
    end
    last_row = (cfg.frame_height == '0) ? 16'd0 : cfg.frame_height - 16'd1;
  end

  assign is_last = (col_r >= last_col);
  assign win_ok  = (row_r >= 16'd2) && (col_r >= CW'(2));

  assign q_push       = s1_full_r && q_ready;
  assign in_ch.ready  = !s1_full_r || q_ready;
  assign accept       = in_ch.valid && in_ch.ready;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (is_last) begin
        col_nxt = '0;
        row_nxt = (row_r >= last_row) ? 16'd0 : row_r + 16'd1;
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      s1_full_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (accept) begin
        s1_full_r <= 1'b1;
      end else if (q_push) begin
        s1_full_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r     <= in_ch.pixel_in;
      s1_col_r    <= col_r;
      s1_win_ok_r <= win_ok;
      s1_last_r   <= is_last;
    end
  end

  // read-before-write; a read of the entry being written this cycle
  // takes the new data from the bypass register instead
  always_ff @(posedge clk) begin
    if (q_push) begin
      lstore[s1_col_r] <= {s1_lines[7:0], s1_px_r};
    end
    if (accept) begin
      mem_q_r <= lstore[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byp_sel_r <= q_push && (s1_col_r == col_r);
      byp_r     <= {s1_lines[7:0], s1_px_r};
    end
  end

  assign s1_lines = byp_sel_r ? byp_r : mem_q_r;

  assign q_item.px       = s1_px_r;
  assign q_item.line0    = s1_lines[15:8];
  assign q_item.line1    = s1_lines[7:0];
  assign q_item.win_ok   = s1_win_ok_r;
  assign q_item.row_last = s1_last_r;

endmodule

`default_nettype wire

// ===== rtl/s3f_queue.sv =====
// ----------------------------------------------------------------------------
// s3f_queue
// Short FIFO between front and back so either side can stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module s3f_queue
  import s3f_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire item_t push_item,
  input  wire logic  push,
  output logic       push_ready,
  output item_t      pop_item,
  output logic       pop_valid,
  input  wire logic  pop
);

  localparam int PW = $clog2(Q_DEPTH);
  localparam int NW = $clog2(Q_DEPTH + 1);

  item_t         slots [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;

  assign push_ready = (count_r != NW'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slots[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + NW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/s3f_back.sv =====
// ----------------------------------------------------------------------------
// s3f_back
// 3x3 window, filter arithmetic and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module s3f_back
  import s3f_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire item_t q_item,
  input  wire logic  q_valid,
  output logic       q_pop,
  s3f_out_if.source  out_ch
);

  logic [7:0]  win_r [3][3];
  logic [7:0]  nw    [3][3];

  logic [10:0] gx_p, gx_n, gy_p, gy_n, ax, ay;
  logic [11:0] sob_sum, gau_sum;
  logic [10:0] shp_pos, shp_neg, shp_diff;
  logic [7:0]  sobel_px, gauss_px, sharp_px, res;

  logic        out_valid_r;
  logic [7:0]  pixel_out_r;
  logic        row_last_r;

  assign q_pop = q_valid && (!out_valid_r || out_ch.ready);

  // window as it stands once this pixel has been shifted in
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nw[i][0] = win_r[i][1];
      nw[i][1] = win_r[i][2];
    end
    nw[0][2] = q_item.line0;
    nw[1][2] = q_item.line1;
    nw[2][2] = q_item.px;
  end

  always_comb begin
    gx_p = {3'b0, nw[0][2]} + {2'b0, nw[1][2], 1'b0} + {3'b0, nw[2][2]};
    gx_n = {3'b0, nw[0][0]} + {2'b0, nw[1][0], 1'b0} + {3'b0, nw[2][0]};
    gy_p = {3'b0, nw[2][0]} + {2'b0, nw[2][1], 1'b0} + {3'b0, nw[2][2]};
    gy_n = {3'b0, nw[0][0]} + {2'b0, nw[0][1], 1'b0} + {3'b0, nw[0][2]};
    ax   = (gx_p >= gx_n) ? gx_p - gx_n : gx_n - gx_p;
    ay   = (gy_p >= gy_n) ? gy_p - gy_n : gy_n - gy_p;
    sob_sum  = {1'b0, ax} + {1'b0, ay};
    sobel_px = (sob_sum > 12'd255) ? PIX_MAX : sob_sum[7:0];

    gau_sum = {4'b0, nw[0][0]} + {3'b0, nw[0][1], 1'b0} + {4'b0, nw[0][2]}
            + {3'b0, nw[1][0], 1'b0} + {2'b0, nw[1][1], 2'b0} + {3'b0, nw[1][2], 1'b0}
            + {4'b0, nw[2][0]} + {3'b0, nw[2][1], 1'b0} + {4'b0, nw[2][2]};
    gauss_px = gau_sum[11:4];

    shp_pos = {1'b0, nw[1][1], 2'b0} + {3'b0, nw[1][1]};
    shp_neg = {3'b0, nw[0][1]} + {3'b0, nw[1][0]} + {3'b0, nw[1][2]} + {3'b0, nw[2][1]};
    shp_diff = shp_pos - shp_neg;
    if (shp_neg > shp_pos) begin
      sharp_px = 8'd0;
    end else if (shp_diff > 11'd255) begin
      sharp_px = PIX_MAX;
    end else begin
      sharp_px = shp_diff[7:0];
    end
  end

  always_comb begin
    case (cfg.filter_mode)
      MODE_SOBEL:     res = q_item.win_ok ? sobel_px : 8'd0;
      MODE_THRESHOLD: res = (q_item.px > cfg.threshold_level) ? PIX_MAX : 8'd0;
      MODE_GAUSSIAN:  res = q_item.win_ok ? gauss_px : q_item.px;
      MODE_NEGATIVE:  res = PIX_MAX - q_item.px;
      MODE_SHARPEN:   res = q_item.win_ok ? sharp_px : q_item.px;
      default:        res = q_item.px;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= nw[i][j];
        end
      end
      pixel_out_r <= res;
      row_last_r  <= q_item.row_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel_out = pixel_out_r;
  assign out_ch.row_last  = row_last_r;

endmodule

`default_nettype wire

// ===== rtl/selectable_3x3_image_filter_top.sv =====
// ----------------------------------------------------------------------------
// selectable_3x3_image_filter_top
// Line-buffered 3x3 filter: pass, Sobel, threshold, Gaussian, negative,
// sharpen, on a raster stream of 8-bit grayscale pixels.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  in_ch     sink       pixel_in[7:0]
//  out_ch    source     pixel_out[7:0], row_last
//  cfg_*     write      cfg_we, cfg_idx[1:0], cfg_wdata[15:0]
//
// One pixel per cycle sustained while the output keeps accepting beats; from
// input beat to output beat a pixel passes the registered line store read,
// the queue slot and the output register. The line store has one read and
// one write port. Synchronous reset clears counters, handshake state and
// configuration; the line store and window are not cleared. A stalled output
// fills the four-entry queue before the input drops ready.
// ----------------------------------------------------------------------------
`default_nettype none

module selectable_3x3_image_filter_top
  import s3f_pkg::*;
#(
  parameter int MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  s3f_in_if.sink                     in_ch,
  s3f_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t  cfg_r;
  item_t f_item, b_item;
  logic  q_push, q_ready, q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_mode     <= FILTER_MODE_RST;
      cfg_r.threshold_level <= THRESHOLD_RST;
      cfg_r.row_width       <= ROW_WIDTH_RST;
      cfg_r.frame_height    <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FILTER_MODE:     cfg_r.filter_mode     <= cfg_wdata[2:0];
        REG_THRESHOLD_LEVEL: cfg_r.threshold_level <= cfg_wdata[7:0];
        REG_ROW_WIDTH:       cfg_r.row_width       <= cfg_wdata[10:0];
        REG_FRAME_HEIGHT:    cfg_r.frame_height    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  s3f_front #(
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_ch   (in_ch),
    .q_item  (f_item),
    .q_push  (q_push),
    .q_ready (q_ready)
  );

  s3f_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_item  (f_item),
    .push       (q_push),
    .push_ready (q_ready),
    .pop_item   (b_item),
    .pop_valid  (q_valid),
    .pop        (q_pop)
  );

  s3f_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_item  (b_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ===== verif/selectable_3x3_image_filter_top_test.sv =====
// ----------------------------------------------------------------------------
// selectable_3x3_image_filter_top_test
// Self-checking bench for the 3x3 line-buffered image filter. A scoreboard
// model tracks counters, line stores and window per accepted pixel beat and
// queues the filtered pixel and row-last mark; every output beat is checked
// against the oldest queued entry. Directed frames cover reset values, size
// extremes and every mode, the widest row with one long output stall; random
// phases then vary the settings under random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module selectable_3x3_image_filter_top_test;
  import s3f_pkg::*;

  localparam int LINE_PIXELS  = MAX_ROW_PIXELS_DEF;
  localparam int IDLE_PCT     = 38;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 20;
  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 500000;

  // pass-through modes not named in the package
  localparam logic [2:0] MODE_BYPASS   = 3'd0;
  localparam logic [2:0] MODE_GRAY     = 3'd1;
  localparam logic [2:0] MODE_PASS_ALT = 3'd7;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_last;
  } out_beat_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  s3f_in_if  in_ch ();
  s3f_out_if out_ch ();

  selectable_3x3_image_filter_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scoreboard copy of settings and state
  logic [2:0]  mode_q;
  logic [7:0]  thr_q;
  logic [10:0] width_q;
  logic [15:0] height_q;
  logic [9:0]  col_cnt;
  logic [15:0] row_cnt;
  logic [7:0]  nbhd [3][3];
  logic [7:0]  line_mem [2][LINE_PIXELS];

  out_beat_t pending_pixels [$];
  out_beat_t oldest;
  int        error_count = 0;
  int        cycle_count = 0;

  logic steady;          // no idling on either side
  logic pressure_armed;  // ask the receiver for one long hold-off
  int   hold_left = 0;
  logic hold_used = 1'b0;

  function automatic logic [7:0] clamp_pixel(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return PIX_MAX;
    return 8'(v);
  endfunction

  function automatic logic [7:0] random_pixel();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return PIX_MAX;
      default: return 8'($urandom);
    endcase
  endfunction

  // advance the scoreboard by one accepted pixel and queue its result
  task automatic filter_pixel(input logic [7:0] px);
    int w, h, c, i, gx, gy, acc;
    logic win_ok, row_end;
    logic [7:0] res;
    w = (width_q == 0) ? 1 : ((int'(width_q) > LINE_PIXELS) ? LINE_PIXELS : int'(width_q));
    h = (height_q == 0) ? 1 : int'(height_q);
    c = int'(col_cnt) % LINE_PIXELS;
    for (i = 0; i < 3; i++) begin
      nbhd[i][0] = nbhd[i][1];
      nbhd[i][1] = nbhd[i][2];
    end
    nbhd[0][2] = line_mem[0][c];
    nbhd[1][2] = line_mem[1][c];
    nbhd[2][2] = px;
    line_mem[0][c] = line_mem[1][c];
    line_mem[1][c] = px;
    win_ok = (row_cnt >= 2) && (col_cnt >= 2);
    case (mode_q)
      MODE_SOBEL: begin
        if (win_ok) begin
          gx = int'(nbhd[0][2]) + 2 * int'(nbhd[1][2]) + int'(nbhd[2][2])
             - int'(nbhd[0][0]) - 2 * int'(nbhd[1][0]) - int'(nbhd[2][0]);
          gy = int'(nbhd[2][0]) + 2 * int'(nbhd[2][1]) + int'(nbhd[2][2])
             - int'(nbhd[0][0]) - 2 * int'(nbhd[0][1]) - int'(nbhd[0][2]);
          if (gx < 0) gx = -gx;
          if (gy < 0) gy = -gy;
          res = clamp_pixel(gx + gy);
        end else begin
          res = 8'd0;
        end
      end
      MODE_THRESHOLD: res = (px > thr_q) ? PIX_MAX : 8'd0;
      MODE_GAUSSIAN: begin
        if (win_ok) begin
          acc = int'(nbhd[0][0]) + 2 * int'(nbhd[0][1]) + int'(nbhd[0][2])
              + 2 * int'(nbhd[1][0]) + 4 * int'(nbhd[1][1]) + 2 * int'(nbhd[1][2])
              + int'(nbhd[2][0]) + 2 * int'(nbhd[2][1]) + int'(nbhd[2][2]);
          res = 8'(acc >> 4);
        end else begin
          res = px;
        end
      end
      MODE_NEGATIVE: res = PIX_MAX - px;
      MODE_SHARPEN: begin
        if (win_ok) begin
          acc = 5 * int'(nbhd[1][1]) - int'(nbhd[0][1]) - int'(nbhd[1][0])
              - int'(nbhd[1][2]) - int'(nbhd[2][1]);
          res = clamp_pixel(acc);
        end else begin
          res = px;
        end
      end
      default: res = px;
    endcase
    // a count at or past the last position ends the row (frame) at once
    row_end = int'(col_cnt) >= w - 1;
    if (row_end) begin
      col_cnt = '0;
      if (int'(row_cnt) >= h - 1) row_cnt = '0;
      else row_cnt = row_cnt + 16'd1;
    end else begin
      col_cnt = col_cnt + 10'd1;
    end
    pending_pixels.push_back('{pixel: res, row_last: row_end});
  endtask

  task automatic send_pixel(input logic [7:0] px);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid    <= 1'b0;
      in_ch.pixel_in <= 8'($urandom);
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.pixel_in <= px;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    filter_pixel(px);
  endtask

  // drop valid right after the last beat, then wait for every result
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FILTER_MODE:     mode_q   = value[2:0];
      REG_THRESHOLD_LEVEL: thr_q    = value[7:0];
      REG_ROW_WIDTH:       width_q  = value[10:0];
      REG_FRAME_HEIGHT:    height_q = value[15:0];
      default: ;
    endcase
  endtask

  task automatic send_frame(input logic [7:0] pix [9]);
    int i;
    for (i = 0; i < 9; i++) send_pixel(pix[i]);
  endtask

  // reset settings: pass mode, 640-pixel rows, threshold at zero
  task automatic test_reset_values();
    int i;
    for (i = 0; i < 642; i++) send_pixel(random_pixel());
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_THRESHOLD));
    send_pixel(8'd0);
    send_pixel(8'd1);
    send_pixel(PIX_MAX);
    send_pixel(8'd128);
  endtask

  // zero width and height both act as one; also wraps counters mid-row
  task automatic test_zero_sizes();
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_SOBEL));
    write_reg(REG_ROW_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '0);
    send_pixel(8'd0);
    send_pixel(PIX_MAX);
    send_pixel(8'd77);
    send_pixel(PIX_MAX);
  endtask

  // oversized width clamps to the line store depth; fills both line stores
  task automatic test_widest_row();
    int i;
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_GAUSSIAN));
    write_reg(REG_ROW_WIDTH, 16'd2047);
    write_reg(REG_FRAME_HEIGHT, 16'd3);
    steady = 1'b1;
    for (i = 0; i < 3 * LINE_PIXELS; i++) begin
      if (i == LINE_PIXELS) steady = 1'b0;
      if (i == 2 * LINE_PIXELS - 100) pressure_armed = 1'b1;
      send_pixel(random_pixel());
    end
  endtask

  // one 3x3 frame of per-pixel modes
  task automatic test_point_modes();
    write_reg(REG_ROW_WIDTH, 16'd3);
    write_reg(REG_FRAME_HEIGHT, 16'd3);
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_BYPASS));
    send_pixel(8'd0);
    send_pixel(PIX_MAX);
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_GRAY));
    send_pixel(PIX_MAX);
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_PASS_ALT));
    send_pixel(8'h5A);
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_THRESHOLD));
    write_reg(REG_THRESHOLD_LEVEL, 16'd254);
    send_pixel(8'd254);
    send_pixel(PIX_MAX);
    write_reg(REG_THRESHOLD_LEVEL, 16'd255);
    send_pixel(PIX_MAX);
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_NEGATIVE));
    send_pixel(8'd0);
    send_pixel(PIX_MAX);
  endtask

  // saturating and clamping windows; each frame gives one full window
  task automatic test_window_extremes();
    logic [7:0] frame [9];
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_SOBEL));
    frame = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255};
    send_frame(frame);
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_GAUSSIAN));
    frame = '{default: 8'd255};
    send_frame(frame);
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_SHARPEN));
    frame = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
    send_frame(frame);
    frame = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};
    send_frame(frame);
  endtask

  task automatic test_random_phases();
    int sent, n, k, pick;
    logic [CFG_DATA_W-1:0] val;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      write_reg(REG_FILTER_MODE, CFG_DATA_W'($urandom_range(0, 7)));
      if ($urandom_range(0, 1) == 1)
        write_reg(REG_THRESHOLD_LEVEL, CFG_DATA_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 60) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) val = CFG_DATA_W'($urandom_range(1, 12));
        else if (pick < 88) val = CFG_DATA_W'($urandom_range(13, 64));
        else if (pick < 94) val = '0;
        else val = CFG_DATA_W'($urandom_range(1024, 2047));
        write_reg(REG_ROW_WIDTH, val);
      end
      if ($urandom_range(0, 99) < 60) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) val = CFG_DATA_W'($urandom_range(1, 6));
        else if (pick < 85) val = CFG_DATA_W'($urandom_range(7, 20));
        else if (pick < 92) val = '0;
        else val = CFG_DATA_W'($urandom_range(0, 65535));
        write_reg(REG_FRAME_HEIGHT, val);
      end
      n = $urandom_range(8, 48);
      for (k = 0; k < n; k++) send_pixel(random_pixel());
      sent += n;
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (pressure_armed && !hold_used) begin
      out_ch.ready <= 1'b0;
      hold_left = HOLD_CYCLES;
      hold_used = 1'b1;
    end else begin
      out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got pixel %0d row_last %0b",
                 $time, out_ch.pixel_out, out_ch.row_last);
        error_count++;
      end else begin
        oldest = pending_pixels.pop_front();
        if (oldest.pixel !== out_ch.pixel_out) begin
          $display("%0t: pixel_out mismatch, expected %0d, got %0d",
                   $time, oldest.pixel, out_ch.pixel_out);
          error_count++;
        end
        if (oldest.row_last !== out_ch.row_last) begin
          $display("%0t: row_last mismatch, expected %0b, got %0b",
                   $time, oldest.row_last, out_ch.row_last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("selectable_3x3_image_filter_top_test: errors");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.pixel_in = '0;
    out_ch.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_FILTER_MODE;
    cfg_wdata      = '0;
    steady         = 1'b0;
    pressure_armed = 1'b0;
    mode_q         = FILTER_MODE_RST;
    thr_q          = THRESHOLD_RST;
    width_q        = ROW_WIDTH_RST;
    height_q       = FRAME_HEIGHT_RST;
    col_cnt        = '0;
    row_cnt        = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_zero_sizes();
    test_widest_row();
    test_point_modes();
    test_window_extremes();
    test_random_phases();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("selectable_3x3_image_filter_top_test: clean");
    end else begin
      $display("selectable_3x3_image_filter_top_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
